FILE: rtl/core/sorted_key_table_defines.svh
// Assertion macros shared by the sorted key table modules.
// Depends on nothing; included by files that assert.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SKT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/skt_pkg.sv
// Package for the sorted key table: status codes, commands and sizes.
// Depends on nothing.
package skt_pkg;
  localparam int CAPACITY_DEF = 256;
  localparam int TEXT_BITS_DEF = 64;
  localparam int FIELD_TEXT = 64;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  typedef struct packed {
    logic load;      // capture item, reset search bounds
    logic probe;     // read key at mid
    logic narrow;    // apply probe result to bounds
    logic check;     // read key at slot-1
    logic judge;     // form status
    logic step;      // one shift move
    logic commit;    // final write / count update
    logic rd;        // read entry at index
    logic finish;    // load result register
  } skt_cmd_t;

  typedef struct packed {
    logic search_done;
    logic shift_done;
    logic ok;
  } skt_sts_t;
endpackage

FILE: rtl/core/skt_datapath.sv
// Datapath of the sorted key table: entry memory, binary search, shifting.
// Depends on skt_pkg and sorted_key_table_defines.svh.
`include "sorted_key_table_defines.svh"
module skt_datapath #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
  parameter int TEXT_BITS = skt_pkg::TEXT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  skt_pkg::skt_cmd_t cmd,
  output skt_pkg::skt_sts_t sts,
  input  logic [1:0] kind,
  input  logic signed [31:0] key,
  input  logic [7:0] index,
  input  logic [15:0] year,
  input  logic [63:0] condition_text,
  input  logic [63:0] type_text,
  output logic [2:0] status,
  output logic [7:0] position,
  output logic signed [31:0] entry_key,
  output logic [15:0] entry_year,
  output logic [63:0] entry_condition,
  output logic [63:0] entry_type,
  output logic [8:0] entry_count
);
  import skt_pkg::*;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 32 + 16 + 2 * TEXT_BITS;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic [EW-1:0] wdata;
  logic wen;

  logic [1:0] op;
  logic [31:0] k;
  logic [7:0] idx;
  logic [EW-1:0] item;
  logic [CW-1:0] fill, lo, hi, slot, cur;
  logic [2:0] st;
  logic [CW-1:0] mid;
  logic [CW-1:0] mid_c;
  logic hit;
  logic [EW-1:0] carry;

  assign mid_c = lo + ((hi - lo) >> 1);
  assign hit = (slot != 0) && (rdata[EW-1 -: 32] == k);
  assign sts.search_done = (lo == hi);
  assign sts.ok = (st == ST_OK);
  assign sts.shift_done = (op == KIND_INSERT) ? (cur == slot) : (cur + 1'b1 >= fill);

  always_comb begin
    raddr = mid_c[AW-1:0];
    if (cmd.check) raddr = AW'(lo - 1'b1);
    else if (cmd.rd) raddr = AW'(idx);
    else if (cmd.step)
      raddr = (op == KIND_INSERT) ? AW'(cur - 1'b1) : AW'(cur + 1'b1);
    wen = 1'b0;
    waddr = AW'(cur);
    wdata = rdata;
    if (cmd.commit && st == ST_OK) begin
      if (op == KIND_INSERT) begin
        wen = 1'b1; waddr = AW'(slot); wdata = item;
      end else if (op == KIND_UPDATE) begin
        wen = 1'b1; waddr = AW'(slot - 1'b1); wdata = {carry[EW-1 -: 32], item[EW-33:0]};
      end
    end
  end

  // shift moves: read in step, write in the following cycle
  logic mv;
  always_ff @(posedge clk) begin
    if (rst) mv <= 1'b0;
    else mv <= cmd.step;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (mv) mem[AW'(cur)] <= rdata;
    else if (wen) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      if (cmd.load) begin
        op <= kind; k <= key; idx <= index;
        item <= {key, year, condition_text[TEXT_BITS-1:0], type_text[TEXT_BITS-1:0]};
        lo <= '0; hi <= fill; mid <= '0;
      end
      if (cmd.probe) mid <= mid_c;
      if (cmd.narrow) begin
        if ((rdata[EW-1 -: 32] ^ 32'h8000_0000) <= (k ^ 32'h8000_0000)) lo <= mid + 1'b1;
        else hi <= mid;
      end
      if (cmd.check) slot <= lo;
      if (cmd.judge) begin
        carry <= rdata;
        if (op == KIND_INSERT) begin
          st <= hit ? ST_DUP : (fill >= CW'(CAPACITY) ? ST_FULL : ST_OK);
          cur <= fill;
        end else begin
          st <= hit ? ST_OK : ST_MISSING;
          cur <= slot - 1'b1;
        end
      end
      if (mv) cur <= (op == KIND_INSERT) ? cur - 1'b1 : cur + 1'b1;
      if (cmd.commit && st == ST_OK) begin
        if (op == KIND_INSERT) fill <= fill + 1'b1;
        else if (op == KIND_DELETE) fill <= fill - 1'b1;
      end
      if (cmd.finish) begin
        entry_key <= '0; entry_year <= '0; entry_condition <= '0; entry_type <= '0;
        entry_count <= 9'(fill);
        case (op)
          KIND_INSERT: begin
            status <= st;
            position <= (st == ST_DUP) ? 8'(slot - 1'b1) : 8'(slot);
          end
          KIND_READ: begin
            position <= idx;
            if (32'(idx) >= 32'(fill)) status <= ST_RANGE;
            else begin
              status <= ST_OK;
              entry_key <= rdata[EW-1 -: 32];
              entry_year <= rdata[EW-33 -: 16];
              entry_condition <= 64'(rdata[2*TEXT_BITS-1 -: TEXT_BITS]);
              entry_type <= 64'(rdata[TEXT_BITS-1:0]);
            end
          end
          default: begin
            status <= st;
            position <= (st == ST_OK) ? 8'(slot - 1'b1) : 8'd0;
          end
        endcase
      end
    end
  end

  `SKT_ASSERT_IMP(a_bounds, cmd.narrow, lo <= hi)
  `SKT_ASSERT_IMP(a_fill, 1'b1, fill <= CW'(CAPACITY))
  `SKT_ASSERT_NEXT(a_mv, cmd.step, mv)
endmodule

FILE: rtl/core/skt_control.sv
// Controller of the sorted key table: sequences search, shift and result.
// Depends on skt_pkg and sorted_key_table_defines.svh.
`include "sorted_key_table_defines.svh"
module skt_control (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic [1:0] kind,
  output skt_pkg::skt_cmd_t cmd,
  input  skt_pkg::skt_sts_t sts
);
  import skt_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_PROBE = 4'd1, S_NARROW = 4'd2, S_CHECK = 4'd3,
    S_JUDGE = 4'd4, S_DECIDE = 4'd5, S_STEP = 4'd6, S_MOVE = 4'd7, S_COMMIT = 4'd8,
    S_READ = 4'd9, S_RWAIT = 4'd10, S_FIN = 4'd11;
  logic [3:0] state, state_next;
  logic [1:0] op;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.load = 1'b1;
        state_next = (kind == KIND_READ) ? S_READ : S_PROBE;
      end
      S_PROBE: if (sts.search_done) state_next = S_CHECK;
               else begin cmd.probe = 1'b1; state_next = S_NARROW; end
      S_NARROW: begin cmd.narrow = 1'b1; state_next = S_PROBE; end
      S_CHECK: begin cmd.check = 1'b1; state_next = S_JUDGE; end
      S_JUDGE: begin cmd.judge = 1'b1; state_next = S_DECIDE; end
      S_DECIDE: state_next = S_STEP;
      S_STEP: begin
        if (!sts.ok || op == KIND_UPDATE || sts.shift_done) state_next = S_COMMIT;
        else begin cmd.step = 1'b1; state_next = S_MOVE; end
      end
      S_MOVE: state_next = S_STEP;
      S_COMMIT: begin cmd.commit = 1'b1; state_next = S_FIN; end
      S_READ: state_next = S_RWAIT;
      S_RWAIT: begin cmd.rd = 1'b1; state_next = S_FIN; end
      S_FIN: begin cmd.finish = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) op <= kind;
      if (cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  `SKT_ASSERT_NEXT(a_fin, cmd.finish, out_valid)
  `SKT_ASSERT_IMP(a_busy, state != S_IDLE, in_stall)
  `SKT_ASSERT_IMP(a_onecmd, 1'b1, $onehot0({cmd.load, cmd.probe, cmd.narrow, cmd.commit}))
endmodule

FILE: rtl/core/sorted_key_table.sv
// Top level of the sorted key table: controller plus datapath.
// Depends on skt_pkg, skt_control and skt_datapath.
// One item at a time: a read goes through the read, read-wait and finish states;
// insert, update and delete run a binary search over the entry memory, and an
// insert or delete then moves one entry per step when it shifts the table.
// The result is held in an output register until taken; the next item is
// accepted once that register is free.
module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
  parameter int TEXT_BITS = skt_pkg::TEXT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] kind,
  input  logic signed [31:0] key,
  input  logic [7:0] index,
  input  logic [15:0] year,
  input  logic [63:0] condition_text,
  input  logic [63:0] type_text,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] status,
  output logic [7:0] position,
  output logic signed [31:0] entry_key,
  output logic [15:0] entry_year,
  output logic [63:0] entry_condition,
  output logic [63:0] entry_type,
  output logic [8:0] entry_count
);
  import skt_pkg::*;
  skt_cmd_t cmd;
  skt_sts_t sts;

  skt_control u_ctl (.clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .kind, .cmd, .sts);

  skt_datapath #(.CAPACITY(CAPACITY), .TEXT_BITS(TEXT_BITS)) u_dp (.clk, .rst, .cmd,
    .sts, .kind, .key, .index, .year, .condition_text, .type_text, .status, .position,
    .entry_key, .entry_year, .entry_condition, .entry_type, .entry_count);
endmodule

FILE: tb/tb_sorted_key_table.sv
// Self-checking bench for sorted_key_table: a directed table, then random
// insert/update/delete/read traffic under idle and stall patterns, checked
// against a behavioural copy of the table. Depends on skt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sorted_key_table;
  import skt_pkg::*;

  localparam int DEPTH = CAPACITY_DEF;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [2:0] status;
    logic [7:0] position;
    logic signed [31:0] key;
    logic [15:0] year;
    logic [63:0] cond;
    logic [63:0] typ;
    logic [8:0] count;
  } table_result_t;

  typedef struct {
    logic [1:0] kind;
    logic signed [31:0] key;
    logic [7:0] index;
    logic [15:0] year;
    logic [63:0] cond;
    logic [63:0] typ;
    bit typed;
    logic [2:0] status;
    logic [7:0] position;
    logic [8:0] count;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = KIND_READ;
  logic signed [31:0] key = '0;
  logic [7:0] index = '0;
  logic [15:0] year = '0;
  logic [63:0] condition_text = '0;
  logic [63:0] type_text = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [7:0] position;
  logic signed [31:0] entry_key;
  logic [15:0] entry_year;
  logic [63:0] entry_condition;
  logic [63:0] entry_type;
  logic [8:0] entry_count;

  logic signed [31:0] tbl_key [DEPTH];
  logic [15:0] tbl_year [DEPTH];
  logic [63:0] tbl_cond [DEPTH];
  logic [63:0] tbl_type [DEPTH];
  int tbl_fill = 0;

  table_result_t pending_results [$];
  int errors = 0;
  int stall_pct = 0;
  int idle_pct = 0;
  int cycle_no = 0;
  int quiet_cycles = 0;
  logic signed [31:0] key_pool [48];

  localparam logic signed [31:0] KMIN = 32'sh8000_0000;
  localparam logic signed [31:0] KMAX = 32'sh7fff_ffff;

  table_row_t directed [22] = '{
    '{KIND_READ, 0, 8'd0, 0, 0, 0, 1, ST_RANGE, 8'd0, 9'd0},
    '{KIND_READ, 0, 8'd255, 0, 0, 0, 1, ST_RANGE, 8'd255, 9'd0},
    '{KIND_UPDATE, 5, 0, 16'h1234, 1, 2, 1, ST_MISSING, 8'd0, 9'd0},
    '{KIND_DELETE, KMIN, 0, 0, 0, 0, 1, ST_MISSING, 8'd0, 9'd0},
    '{KIND_INSERT, 0, 0, 16'd1999, 64'h4e45_5700, 64'h4d50_3300, 1, ST_OK, 8'd0, 9'd1},
    '{KIND_INSERT, KMAX, 8'hff, 16'hffff, '1, '1, 1, ST_OK, 8'd1, 9'd2},
    '{KIND_INSERT, KMIN, 0, 0, 0, 0, 1, ST_OK, 8'd0, 9'd3},
    '{KIND_INSERT, 0, 0, 16'd5, 5, 5, 1, ST_DUP, 8'd1, 9'd3},
    '{KIND_INSERT, -1, 0, 16'd7, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
      0, 0, 0, 0},
    '{KIND_READ, 0, 8'd0, 0, 0, 0, 0, 0, 0, 0},
    '{KIND_READ, 0, 8'd1, 0, 0, 0, 0, 0, 0, 0},
    '{KIND_READ, 0, 8'd2, 0, 0, 0, 0, 0, 0, 0},
    '{KIND_READ, 0, 8'd3, 0, 0, 0, 0, 0, 0, 0},
    '{KIND_READ, 0, 8'd4, 0, 0, 0, 1, ST_RANGE, 8'd4, 9'd4},
    '{KIND_UPDATE, KMAX, 0, 16'h0001, 64'h8000_0000_0000_0001, 64'h1, 0, 0, 0, 0},
    '{KIND_READ, 0, 8'd3, 0, 0, 0, 0, 0, 0, 0},
    '{KIND_UPDATE, 7, 0, 0, 0, 0, 1, ST_MISSING, 8'd0, 9'd4},
    '{KIND_DELETE, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{KIND_DELETE, KMIN, 0, 0, 0, 0, 0, 0, 0, 0},
    '{KIND_DELETE, KMAX, 0, 0, 0, 0, 0, 0, 0, 0},
    '{KIND_DELETE, KMAX, 0, 0, 0, 0, 1, ST_MISSING, 8'd0, 9'd1},
    '{KIND_READ, 0, 8'd0, 0, 0, 0, 0, 0, 0, 0}
  };

  sorted_key_table i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .key(key), .index(index), .year(year),
    .condition_text(condition_text), .type_text(type_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .position(position), .entry_key(entry_key),
    .entry_year(entry_year), .entry_condition(entry_condition),
    .entry_type(entry_type), .entry_count(entry_count)
  );

  always #10 clk = ~clk;

  function automatic table_result_t apply_request(logic [1:0] k, logic signed [31:0] kk,
                                                  logic [7:0] idx, logic [15:0] yr,
                                                  logic [63:0] c, logic [63:0] t);
    table_result_t r;
    int slot;
    int i;
    bit found;
    r = '{default: '0};
    slot = 0;
    for (i = 0; i < tbl_fill; i++) if (tbl_key[i] <= kk) slot = i + 1;
    found = slot > 0 && tbl_key[slot - 1] == kk;
    case (k)
      KIND_INSERT: begin
        if (found) begin
          r.status = ST_DUP;
          r.position = 8'(slot - 1);
        end else if (tbl_fill >= DEPTH) begin
          r.status = ST_FULL;
          r.position = 8'(slot);
        end else begin
          for (i = tbl_fill; i > slot; i--) begin
            tbl_key[i] = tbl_key[i - 1];
            tbl_year[i] = tbl_year[i - 1];
            tbl_cond[i] = tbl_cond[i - 1];
            tbl_type[i] = tbl_type[i - 1];
          end
          tbl_key[slot] = kk;
          tbl_year[slot] = yr;
          tbl_cond[slot] = c;
          tbl_type[slot] = t;
          tbl_fill++;
          r.status = ST_OK;
          r.position = 8'(slot);
        end
      end
      KIND_UPDATE: begin
        if (!found) r.status = ST_MISSING;
        else begin
          r.status = ST_OK;
          r.position = 8'(slot - 1);
          tbl_year[slot - 1] = yr;
          tbl_cond[slot - 1] = c;
          tbl_type[slot - 1] = t;
        end
      end
      KIND_DELETE: begin
        if (!found) r.status = ST_MISSING;
        else begin
          r.status = ST_OK;
          r.position = 8'(slot - 1);
          for (i = slot - 1; i + 1 < tbl_fill; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_year[i] = tbl_year[i + 1];
            tbl_cond[i] = tbl_cond[i + 1];
            tbl_type[i] = tbl_type[i + 1];
          end
          tbl_fill--;
        end
      end
      default: begin
        r.position = idx;
        if (idx >= tbl_fill) r.status = ST_RANGE;
        else begin
          r.status = ST_OK;
          r.key = tbl_key[idx];
          r.year = tbl_year[idx];
          r.cond = tbl_cond[idx];
          r.typ = tbl_type[idx];
        end
      end
    endcase
    r.count = 9'(tbl_fill);
    return r;
  endfunction

  task automatic offer(table_row_t row);
    table_result_t r;
    in_valid <= 1'b1;
    kind <= row.kind;
    key <= row.key;
    index <= row.index;
    year <= row.year;
    condition_text <= row.cond;
    type_text <= row.typ;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_request(row.kind, row.key, row.index, row.year, row.cond, row.typ);
    if (row.typed) begin
      r.status = row.status;
      r.position = row.position;
      r.count = row.count;
    end
    pending_results.push_back(r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic table_row_t random_request();
    table_row_t row;
    int pick;
    row = '{default: '0};
    pick = $urandom_range(99);
    row.kind = pick < 40 ? KIND_INSERT : pick < 55 ? KIND_UPDATE :
               pick < 80 ? KIND_DELETE : KIND_READ;
    row.key = $urandom_range(99) < 85 ? key_pool[$urandom_range(47)] : $urandom;
    if (row.kind != KIND_INSERT && tbl_fill > 0 && $urandom_range(99) < 70)
      row.key = tbl_key[$urandom_range(tbl_fill - 1)];
    if (tbl_fill > 0 && $urandom_range(99) < 80) row.index = $urandom_range(tbl_fill - 1);
    else row.index = $urandom_range(255);
    row.year = $urandom;
    row.cond = {$urandom, $urandom};
    row.typ = {$urandom, $urandom};
    return row;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected item: expected none, got status %0d", $time, status);
        errors++;
      end else begin
        w = pending_results.pop_front();
        check_field("status", w.status, status);
        check_field("position", w.position, position);
        check_field("entry_key", 64'(unsigned'(w.key)), 64'(unsigned'(entry_key)));
        check_field("entry_year", w.year, entry_year);
        check_field("entry_condition", w.cond, entry_condition);
        check_field("entry_type", w.typ, entry_type);
        check_field("entry_count", w.count, entry_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= 2000 && cycle_no < 2400) out_stall <= 1'b1;
    else out_stall <= stall_pct > 0 && $urandom_range(99) < stall_pct;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    table_row_t row;
    int i;
    int n;
    key_pool[0] = KMIN;
    key_pool[1] = KMAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (i = 4; i < 48; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) offer(directed[i]);
    for (n = 0; n < 4; n++) begin
      idle_pct = (n == 1) ? 75 : (n == 3) ? 36 : 0;
      stall_pct = (n == 2) ? 75 : (n == 3) ? 36 : 0;
      repeat (190) offer(random_request());
    end
    idle_pct = 0;
    stall_pct = 0;
    // empty from the top, then fill to capacity with ascending keys
    while (tbl_fill > 0) begin
      row = random_request();
      row.kind = KIND_DELETE;
      row.key = tbl_key[tbl_fill - 1];
      offer(row);
    end
    for (i = 0; i < DEPTH; i++) begin
      row = random_request();
      row.kind = KIND_INSERT;
      row.key = i == 0 ? KMIN : i == DEPTH - 1 ? KMAX :
                KMIN + 32'(i) * 32'sh0100_0000 + $urandom_range(15);
      offer(row);
    end
    row = random_request();
    row.kind = KIND_INSERT;
    row.key = KMIN + 32'sh0100_0000 * 100 + 100;
    offer(row);
    row.key = KMAX - 5;
    offer(row);
    row.key = KMAX;
    offer(row);
    row.kind = KIND_READ;
    row.index = 8'd255;
    offer(row);
    row.index = 8'd0;
    offer(row);
    repeat (6) begin
      row = random_request();
      row.kind = KIND_DELETE;
      row.key = tbl_key[$urandom_range(tbl_fill - 1)];
      offer(row);
      row = random_request();
      row.kind = KIND_INSERT;
      offer(row);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
